// File: rtl/core/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg: shared types and constants of the sliding window min/max core
// Width of the window size register and the states of the control sequencer.
// ----------------------------------------------------------------------------
package swmm_pkg;

    localparam int CFG_WIDTH = 9;

    typedef enum logic [2:0]
    {
        ST_IDLE  = 3'b001,
        ST_WAIT  = 3'b010,
        ST_SWEEP = 3'b100
    } swmm_state_t;

endpackage

// File: rtl/core/sliding_window_min_max_core.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max_core: maximum and minimum over a sliding window
// Input beats carry a signed sample and a restart flag. Once the current
// sequence holds window_size samples, each beat yields one output beat with
// the largest and smallest of the last window_size samples; earlier beats
// yield nothing. window_size is written over the cfg channel (cfg_ready is
// always high); zero acts as one, values above WINDOW_MAX act as WINDOW_MAX.
// A beat is taken when valid is high and stall is low. The history is a
// chain of WINDOW_MAX cells: an accepted sample shifts in at the head, then a
// min/max token runs down the chain one cell per cycle and lands in the
// output register; it runs the whole chain, whatever the window size. One
// beat is in flight at a time: a beat that yields a result holds in_stall
// high until its token leaves the chain, a beat that yields none does not
// raise it. While out_stall is high the result holds in the output register;
// a further input beat is still taken, and its token waits until that
// register empties. Reset clears the fill count, sets window_size to one and
// empties the output; history contents are not cleared.
// ----------------------------------------------------------------------------
module sliding_window_min_max_core
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX   = 256,
    parameter int SAMPLE_WIDTH = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_WIDTH-1:0]           cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           restart,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] window_max,
    output logic signed [SAMPLE_WIDTH-1:0] window_min
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int EW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

    logic [CFG_WIDTH-1:0]           win_size_reg;
    logic [CW-1:0]                  fill_reg;
    logic [CW-1:0]                  fill_next;
    logic [CW-1:0]                  fill_base;
    logic [CW-1:0]                  win_reg;
    logic [CW-1:0]                  win_eff;
    logic [EW-1:0]                  win_ext;
    swmm_state_t                    state_reg;
    swmm_state_t                    state_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] max_reg;
    logic signed [SAMPLE_WIDTH-1:0] min_reg;
    logic                           in_take;
    logic                           out_free;
    logic                           launch;
    logic                           produce;

    logic signed [SAMPLE_WIDTH-1:0] chain_data [WINDOW_MAX+1];
    logic                           chain_valid [WINDOW_MAX+1];
    logic [CW-1:0]                  chain_left [WINDOW_MAX+1];
    logic signed [SAMPLE_WIDTH-1:0] chain_max [WINDOW_MAX+1];
    logic signed [SAMPLE_WIDTH-1:0] chain_min [WINDOW_MAX+1];

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign launch    = (state_reg == ST_WAIT) && out_free;

    // effective window: zero acts as one, clamp at the chain length
    always_comb
    begin
        win_ext = EW'(win_size_reg);
        if (win_ext == '0)
        begin
            win_ext = EW'(1);
        end
        if (win_ext > EW'(WINDOW_MAX))
        begin
            win_ext = EW'(WINDOW_MAX);
        end
        win_eff = CW'(win_ext);
    end

    always_comb
    begin
        fill_base = restart ? '0 : fill_reg;
        fill_next = fill_base;
        if (fill_base < CW'(WINDOW_MAX))
        begin
            fill_next = fill_base + CW'(1);
        end
        produce = (fill_next >= win_eff);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && produce)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (chain_valid[WINDOW_MAX])
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (chain_valid[WINDOW_MAX])
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_size_reg  <= CFG_WIDTH'(1);
            fill_reg      <= '0;
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                win_size_reg <= cfg_data;
            end
            if (in_take)
            begin
                fill_reg <= fill_next;
            end
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            win_reg <= win_eff;
        end
        if (chain_valid[WINDOW_MAX])
        begin
            max_reg <= chain_max[WINDOW_MAX];
            min_reg <= chain_min[WINDOW_MAX];
        end
    end

    // head of the chain: new sample in, token launched from here
    assign chain_data[0]  = sample;
    assign chain_valid[0] = launch;
    assign chain_left[0]  = win_reg;
    assign chain_max[0]   = chain_data[1];
    assign chain_min[0]   = chain_data[1];

    for (genvar k = 0; k < WINDOW_MAX; k++)
    begin : g_cell
        swmm_cell
        #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .COUNT_WIDTH  (CW)
        )
        u_cell
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .shift         (in_take),
            .data_in       (chain_data[k]),
            .data_out      (chain_data[k+1]),
            .tok_in_valid  (chain_valid[k]),
            .tok_in_left   (chain_left[k]),
            .tok_in_max    (chain_max[k]),
            .tok_in_min    (chain_min[k]),
            .tok_out_valid (chain_valid[k+1]),
            .tok_out_left  (chain_left[k+1]),
            .tok_out_max   (chain_max[k+1]),
            .tok_out_min   (chain_min[k+1])
        );
    end

    assign out_valid  = out_valid_reg;
    assign window_max = max_reg;
    assign window_min = min_reg;

endmodule

// File: rtl/core/swmm_cell.sv
// ----------------------------------------------------------------------------
// swmm_cell: one history cell of the sliding window min/max chain
// Holds one sample, shifted in from the neighbour on each accepted beat, and
// folds it into the passing min/max token while the token still has samples
// left to cover.
// ----------------------------------------------------------------------------
module swmm_cell
#(
    parameter int SAMPLE_WIDTH = 32,
    parameter int COUNT_WIDTH  = 9
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           shift,
    input  logic signed [SAMPLE_WIDTH-1:0] data_in,
    output logic signed [SAMPLE_WIDTH-1:0] data_out,
    input  logic                           tok_in_valid,
    input  logic [COUNT_WIDTH-1:0]         tok_in_left,
    input  logic signed [SAMPLE_WIDTH-1:0] tok_in_max,
    input  logic signed [SAMPLE_WIDTH-1:0] tok_in_min,
    output logic                           tok_out_valid,
    output logic [COUNT_WIDTH-1:0]         tok_out_left,
    output logic signed [SAMPLE_WIDTH-1:0] tok_out_max,
    output logic signed [SAMPLE_WIDTH-1:0] tok_out_min
);

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           tok_valid_reg;
    logic [COUNT_WIDTH-1:0]         tok_left_reg;
    logic [COUNT_WIDTH-1:0]         tok_left_next;
    logic signed [SAMPLE_WIDTH-1:0] tok_max_reg;
    logic signed [SAMPLE_WIDTH-1:0] tok_max_next;
    logic signed [SAMPLE_WIDTH-1:0] tok_min_reg;
    logic signed [SAMPLE_WIDTH-1:0] tok_min_next;

    always_comb
    begin
        tok_left_next = tok_in_left;
        tok_max_next  = tok_in_max;
        tok_min_next  = tok_in_min;
        if (tok_in_left != '0)
        begin
            // fold this cell's sample into the token
            tok_left_next = tok_in_left - COUNT_WIDTH'(1);
            if (sample_reg > tok_in_max)
            begin
                tok_max_next = sample_reg;
            end
            if (sample_reg < tok_in_min)
            begin
                tok_min_next = sample_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            sample_reg <= data_in;
        end
        tok_left_reg <= tok_left_next;
        tok_max_reg  <= tok_max_next;
        tok_min_reg  <= tok_min_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in_valid;
        end
    end

    assign data_out      = sample_reg;
    assign tok_out_valid = tok_valid_reg;
    assign tok_out_left  = tok_left_reg;
    assign tok_out_max   = tok_max_reg;
    assign tok_out_min   = tok_min_reg;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sliding window min/max core
// Feeds signed samples with restart flags over several window sizes (zero,
// one, mid-sequence changes, saturating values), predicts the largest and
// smallest sample of each full window, and checks every output beat in order.
// Both sides idle and stall at random, the heavier in turns, or neither idles.
// ----------------------------------------------------------------------------
module tb_top
    import swmm_pkg::*;
();

    localparam int WIN_DEPTH   = 256;
    localparam int SETTLE      = WIN_DEPTH + 4;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int N_PHASES    = 9;

    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

    typedef struct
    {
        logic signed [31:0] hi;
        logic signed [31:0] lo;
    } extremes_t;

    class window_scoreboard;
        logic signed [31:0] held[$];
        logic [CFG_WIDTH-1:0] window_reg;
        extremes_t expected[$];
        int errors;

        function new();
            window_reg = 1;
            errors = 0;
        endfunction

        function void set_window(logic [CFG_WIDTH-1:0] v);
            window_reg = v;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void note_sample(logic signed [31:0] s, logic rs);
            int span;
            int k;
            extremes_t e;
            if (rs)
                held.delete();
            held.push_back(s);
            if (held.size() > WIN_DEPTH)
                void'(held.pop_front());
            span = (window_reg == 0) ? 1 : ((window_reg > WIN_DEPTH) ? WIN_DEPTH : window_reg);
            if (held.size() < span)
                return;
            e.hi = s;
            e.lo = s;
            for (k = 1; k < span; k++)
            begin
                if (held[held.size()-1-k] > e.hi)
                    e.hi = held[held.size()-1-k];
                if (held[held.size()-1-k] < e.lo)
                    e.lo = held[held.size()-1-k];
            end
            expected.push_back(e);
        endfunction

        function void check_result(logic signed [31:0] mx, logic signed [31:0] mn);
            extremes_t e;
            if (expected.size() == 0)
            begin
                $display("%0t: unexpected result beat: max %0d min %0d", $time, mx, mn);
                errors++;
                return;
            end
            e = expected.pop_front();
            if (mx !== e.hi)
            begin
                $display("%0t: window_max expected %0d actual %0d", $time, e.hi, mx);
                errors++;
            end
            if (mn !== e.lo)
            begin
                $display("%0t: window_min expected %0d actual %0d", $time, e.lo, mn);
                errors++;
            end
        endfunction
    endclass

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_WIDTH-1:0]        cfg_data  = '0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic signed [31:0]          sample    = '0;
    logic                        restart   = 1'b0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [31:0]          window_max;
    logic signed [31:0]          window_min;

    window_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count;

    sliding_window_min_max_core #(
        .WINDOW_MAX   (WIN_DEPTH),
        .SAMPLE_WIDTH (32)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .window_max (window_max),
        .window_min (window_min)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(window_max, window_min);
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    function automatic void set_idling(int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 25;
                recv_idle_pct = 46;
            end
            1:
            begin
                send_idle_pct = 46;
                recv_idle_pct = 25;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endfunction

    function automatic logic signed [31:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return S_MAX;
            1:       return S_MIN;
            2, 3:    return $signed($urandom_range(0, 20)) - 10;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_sample(input logic signed [31:0] s, input logic rs);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        restart  <= rs;
        do @(posedge clk); while (in_stall);
        board.note_sample(s, rs);
    endtask

    // hold the input until every expected beat is out, then let the chain settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_WIDTH-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_window(v);
    endtask

    initial
    begin
        logic [CFG_WIDTH-1:0] phase_window[N_PHASES];
        int phase_items[N_PHASES];
        int p;
        int j;
        bit big;

        phase_window = '{2, 5, 511, 17, 0, 300, 3, 64, 1};
        phase_items  = '{80, 80, 300, 80, 60, 40, 80, 80, 50};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(2);
        send_sample(S_MAX, 1'b0);
        send_sample(S_MIN, 1'b0);
        send_sample(0, 1'b1);
        send_sample(-1, 1'b0);

        write_window(CFG_WIDTH'(0));
        send_sample(5, 1'b1);
        send_sample(-5, 1'b0);

        write_window(CFG_WIDTH'(3));
        send_sample(S_MIN, 1'b1);
        send_sample(S_MAX, 1'b0);
        send_sample(0, 1'b0);
        send_sample(-1, 1'b0);

        write_window(CFG_WIDTH'(2));
        send_sample(1, 1'b0);
        write_window(CFG_WIDTH'(6));
        send_sample(3, 1'b0);

        write_window(CFG_WIDTH'(511));
        send_sample(9, 1'b1);
        send_sample(-9, 1'b0);

        for (p = 0; p < N_PHASES; p++)
        begin
            write_window(phase_window[p]);
            set_idling(p % 3);
            big = (phase_window[p] >= 64);
            for (j = 0; j < phase_items[p]; j++)
            begin
                if (j == phase_items[p] / 2 && p % 3 == 1)
                    drain_results();
                send_sample(pick_sample(), $urandom_range(0, big ? 149 : 11) == 0);
            end
        end

        drain_results();
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
